// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// shared types, constants and helpers of the pattern search context capture
// ----------------------------------------------------------------------------
package psc_pkg;

	// parameter defaults
	localparam int unsigned MAX_PATTERN_DEF = 32;
	localparam int unsigned OFFSET_BITS_DEF = 48;

	// pattern length domain, wide enough for any clamped length up to 64
	localparam int unsigned PLEN_W = 7;

	// pattern storage: four 64-bit words
	localparam int unsigned PATTERN_BYTES = 32;
	localparam int unsigned PATTERN_W = PATTERN_BYTES * 8;

	// configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD3 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_LEN = 3'd5;

	localparam logic [5:0] PATTERN_LEN_RST = 6'd1;
	localparam logic [7:0] CONTEXT_LEN_RST = 8'd200;

	// zero bytes of a record go out as this
	localparam logic [7:0] SPACE_BYTE = 8'h20;

	typedef struct packed {
		logic [5:0]           pattern_len;
		logic [PATTERN_W-1:0] pattern;
		logic [7:0]           context_len;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REPLAY
	} psc_state_t;

	// controller to datapath
	typedef struct packed {
		logic shift;       // take the stream byte into the window
		logic emit_cap;    // send the stream byte as a record byte
		logic load_match;  // open a record at the current match
		logic emit_rep;    // send the next replayed window byte
		logic finish_in;   // item done, end of stream taken from the port
		logic finish_held; // item done, end of stream taken from the held flag
	} psc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic cap_active;
		logic hit;
		logic rep_done;
	} psc_stat_t;

	// pattern byte k, zero beyond the stored bytes
	function automatic logic [7:0] pat_byte(input logic [PATTERN_W-1:0] pat,
			input logic [PLEN_W-1:0] k);
		logic [7:0] b;
		b = 8'h00;
		if (k < PLEN_W'(PATTERN_BYTES)) begin
			b = pat[{k[4:0], 3'b000} +: 8];
		end
		return b;
	endfunction

	// record bytes never carry zero
	function automatic logic [7:0] to_context(input logic [7:0] b);
		return (b == 8'h00) ? SPACE_BYTE : b;
	endfunction

endpackage

// ===== rtl/psc_if.sv =====
// ----------------------------------------------------------------------------
// psc_if
// stream and record channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface psc_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface psc_record_if #(
	parameter int unsigned OFFSET_BITS = psc_pkg::OFFSET_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] match_offset;
	logic [7:0]             context_byte;
	logic                   first_of_record;
	logic                   last_of_record;

	modport source (output valid, output match_offset, output context_byte,
		output first_of_record, output last_of_record, input ready);
	modport sink (input valid, input match_offset, input context_byte,
		input first_of_record, input last_of_record, output ready);
endinterface

// ===== rtl/pattern_search_context_capture.sv =====
// ----------------------------------------------------------------------------
// pattern_search_context_capture
// byte pattern search over a continuous stream with context record capture
// ----------------------------------------------------------------------------
// The block watches a byte stream for a configured pattern of 1 to 32 bytes.
// A match that starts at or after the end of the previous record opens a record
// of context_len bytes beginning at the match start: the matched bytes, up to
// context_len of them, are replayed from the byte window one a cycle while the
// output register is free, then the following stream bytes pass through one a
// cycle under the same condition, until the record is full or the stream ends.
// Zero bytes go out as spaces; the first record item carries the stream offset
// of the match. end_of_stream ends any open record and resets the stream state
// (offsets, record counters); registers keep their values. A byte inside a
// record is shifted in and sent out together; any other byte is shifted into
// the window, then checked in a separate step (parallel compare of all window
// taps plus the offset compare); a match then replays min(context_len,
// pattern_len) bytes through the single window read port (a context_len of 0
// counts as 1). A new byte is taken only when the output register is empty or
// its item leaves in the same cycle, so every cycle the record side stalls also
// stalls the input. Registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module pattern_search_context_capture #(
	parameter int unsigned MAX_PATTERN = psc_pkg::MAX_PATTERN_DEF,
	parameter int unsigned OFFSET_BITS = psc_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	psc_stream_if.sink                     stream,
	psc_record_if.source                   record,
	input  logic                           cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import psc_pkg::*;

	cfg_t      cfg;
	psc_cmd_t  cmd;
	psc_stat_t stat;

	// write-only register file
	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencing: idle / match check / replay
	psc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_valid (stream.valid),
		.stream_ready (stream.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// window, compare, offsets and the output register
	psc_dp #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.stat       (stat),
		.in_byte    (stream.data_byte),
		.in_eos     (stream.end_of_stream),
		.out_valid  (record.valid),
		.out_ready  (record.ready),
		.out_offset (record.match_offset),
		.out_byte   (record.context_byte),
		.out_first  (record.first_of_record),
		.out_last   (record.last_of_record)
	);

endmodule

// ===== rtl/psc_cfg.sv =====
// ----------------------------------------------------------------------------
// psc_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module psc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data,
	output psc_pkg::cfg_t                  cfg
);
	import psc_pkg::*;

	logic [5:0]           pattern_len_q;
	logic [PATTERN_W-1:0] pattern_q;
	logic [7:0]           context_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= PATTERN_LEN_RST;
			pattern_q <= '0;
			context_len_q <= CONTEXT_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LEN: pattern_len_q <= cfg_data[5:0];
				REG_PATTERN_WORD0: pattern_q[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD1: pattern_q[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD2: pattern_q[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_PATTERN_WORD3: pattern_q[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_data;
				REG_CONTEXT_LEN: context_len_q <= cfg_data[7:0];
				default: ; // indexes past the list are dropped
			endcase
		end
	end

	assign cfg.pattern_len = pattern_len_q;
	assign cfg.pattern = pattern_q;
	assign cfg.context_len = context_len_q;

endmodule

// ===== rtl/psc_dp.sv =====
// ----------------------------------------------------------------------------
// psc_dp
// datapath: byte window, match compare, offsets, record counters, output register
// ----------------------------------------------------------------------------
module psc_dp #(
	parameter int unsigned MAX_PATTERN = psc_pkg::MAX_PATTERN_DEF,
	parameter int unsigned OFFSET_BITS = psc_pkg::OFFSET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psc_pkg::cfg_t          cfg,
	input  psc_pkg::psc_cmd_t      cmd,
	output psc_pkg::psc_stat_t     stat,
	input  logic [7:0]             in_byte,
	input  logic                   in_eos,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OFFSET_BITS-1:0] out_offset,
	output logic [7:0]             out_byte,
	output logic                   out_first,
	output logic                   out_last
);
	import psc_pkg::*;

	localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [7:0]             window_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] next_start_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic [7:0]             cap_q;
	logic                   eos_q;
	logic [IDX_W-1:0]       rep_idx_q;
	logic [PLEN_W-1:0]      rep_cnt_q;
	logic                   rep_first_q;

	logic                   out_valid_q;
	logic [OFFSET_BITS-1:0] out_offset_q;
	logic [7:0]             out_byte_q;
	logic                   out_first_q;
	logic                   out_last_q;

	logic [PLEN_W-1:0]      plen_raw;
	logic [PLEN_W-1:0]      plen_eff;
	logic [PLEN_W-1:0]      plen_m1;
	logic [7:0]             ctx_eff;
	logic [7:0]             rep_len;
	logic [OFFSET_BITS-1:0] start;
	logic [MAX_PATTERN-1:0] byte_ok;
	logic                   hit;
	logic                   finish;
	logic                   finish_eos;

	// clamped lengths
	assign plen_raw = {1'b0, cfg.pattern_len};
	always_comb begin
		if (plen_raw == '0) begin
			plen_eff = PLEN_W'(1);
		end else if (plen_raw > PLEN_W'(MAX_PATTERN)) begin
			plen_eff = PLEN_W'(MAX_PATTERN);
		end else begin
			plen_eff = plen_raw;
		end
	end
	assign plen_m1 = plen_eff - PLEN_W'(1);
	assign ctx_eff = (cfg.context_len == 8'd0) ? 8'd1 : cfg.context_len;
	assign rep_len = (ctx_eff < 8'(plen_eff)) ? ctx_eff : 8'(plen_eff);

	// window tap i holds the byte i places back; it meets pattern byte plen-1-i
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cmp
		assign byte_ok[i] = (PLEN_W'(i) >= plen_eff)
			|| (window_q[i] == pat_byte(cfg.pattern, plen_m1 - PLEN_W'(i)));
	end

	assign start = pos_q - OFFSET_BITS'(plen_m1);
	assign hit = (pos_q >= OFFSET_BITS'(plen_m1)) && (start >= next_start_q) && (&byte_ok);

	// byte window
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			window_q[0] <= in_byte;
			for (int i = 1; i < MAX_PATTERN; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	assign finish = cmd.finish_in || cmd.finish_held;
	assign finish_eos = (cmd.finish_in && in_eos) || (cmd.finish_held && eos_q);

	// stream offsets and record counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			next_start_q <= '0;
			cap_q <= '0;
			eos_q <= 1'b0;
			rep_idx_q <= '0;
			rep_cnt_q <= '0;
			rep_first_q <= 1'b0;
		end else begin
			if (cmd.shift) begin
				eos_q <= in_eos;
			end
			if (cmd.emit_cap && !finish_eos) begin
				cap_q <= cap_q - 8'd1;
			end
			if (cmd.load_match) begin
				next_start_q <= start + OFFSET_BITS'(ctx_eff);
				cap_q <= ctx_eff - rep_len;
				rep_idx_q <= plen_m1[IDX_W-1:0];
				rep_cnt_q <= PLEN_W'(rep_len - 8'd1);
				rep_first_q <= 1'b1;
			end
			if (cmd.emit_rep) begin
				rep_idx_q <= rep_idx_q - IDX_W'(1);
				rep_cnt_q <= rep_cnt_q - PLEN_W'(1);
				rep_first_q <= 1'b0;
			end
			if (finish) begin
				if (finish_eos) begin
					pos_q <= '0;
					next_start_q <= '0;
					cap_q <= '0;
				end else begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_match) begin
			start_q <= start;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_cap || cmd.emit_rep) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_cap) begin
			out_offset_q <= '0;
			out_byte_q <= to_context(in_byte);
			out_first_q <= 1'b0;
			out_last_q <= (cap_q == 8'd1) || in_eos;
		end else if (cmd.emit_rep) begin
			out_offset_q <= rep_first_q ? start_q : '0;
			out_byte_q <= to_context(window_q[rep_idx_q]);
			out_first_q <= rep_first_q;
			out_last_q <= (rep_cnt_q == '0) && ((cap_q == 8'd0) || eos_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_offset = out_offset_q;
	assign out_byte = out_byte_q;
	assign out_first = out_first_q;
	assign out_last = out_last_q;

	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.cap_active = (cap_q != 8'd0);
	assign stat.hit = hit;
	assign stat.rep_done = (rep_cnt_q == '0);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.emit_cap || cmd.emit_rep))
		else $error("record item overwritten while stalled");

	a_offset_first_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_first_q) |-> (out_offset_q == '0))
		else $error("offset on a record byte that is not the first");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish_eos |=> ((pos_q == '0) && (cap_q == 8'd0) && (next_start_q == '0)))
		else $error("stream state not cleared after end of stream");

endmodule

// ===== rtl/psc_ctrl.sv =====
// ----------------------------------------------------------------------------
// psc_ctrl
// controller: accept, match check and replay sequencing
// ----------------------------------------------------------------------------
module psc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stream_valid,
	output logic               stream_ready,
	input  psc_pkg::psc_stat_t stat,
	output psc_pkg::psc_cmd_t  cmd
);
	import psc_pkg::*;

	psc_state_t state_q;
	psc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		stream_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				stream_ready = stat.slot_free;
				if (stream_valid && stat.slot_free) begin
					cmd.shift = 1'b1;
					if (stat.cap_active) begin
						cmd.emit_cap = 1'b1;
						cmd.finish_in = 1'b1;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stat.hit) begin
					cmd.load_match = 1'b1;
					state_d = ST_REPLAY;
				end else begin
					cmd.finish_held = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_REPLAY: begin
				if (stat.slot_free) begin
					cmd.emit_rep = 1'b1;
					if (stat.rep_done) begin
						cmd.finish_held = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_check_outside_record: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> !stat.cap_active)
		else $error("match check entered inside a record");

	a_replay_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_REPLAY) && !stat.slot_free) |=> (state_q == ST_REPLAY))
		else $error("replay left while output stalled");

	a_replay_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_rep && stat.rep_done) |=> (state_q == ST_IDLE))
		else $error("replay did not end after its last byte");

endmodule

// ===== bench/pattern_search_context_capture_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_search_context_capture_test
// Drives byte streams into the pattern search block and checks every record
// item against an internal prediction of the search, the replay of matched
// bytes, the capture of following bytes and the end of stream handling.
// ----------------------------------------------------------------------------
module pattern_search_context_capture_test;
	import psc_pkg::*;

	localparam int unsigned MAX_PAT = MAX_PATTERN_DEF;
	localparam int unsigned OFS_W = OFFSET_BITS_DEF;
	// long enough for the replay of a full pattern plus a plain byte, with margin
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_REPORTS = 10;

	// one record item as seen on the output channel
	typedef struct packed {
		logic [OFS_W-1:0] match_offset;
		logic [7:0]       context_byte;
		logic             first_of_record;
		logic             last_of_record;
	} record_item_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_SLOW,
		SINK_PERIODIC
	} sink_mode_t;

	// ------------------------------------------------------------------------
	// record predictor and store of expected record items
	// ------------------------------------------------------------------------
	class record_scoreboard;
		// register copies
		logic [5:0]       pat_len_reg;
		logic [255:0]     pattern_reg;
		logic [7:0]       ctx_len_reg;
		// stream state
		logic [7:0]       window [MAX_PAT];
		logic [OFS_W-1:0] position;
		logic [OFS_W-1:0] next_start;
		int unsigned      capture_left;
		record_item_t     pending [$];
		int unsigned      failures;

		function new();
			pat_len_reg = PATTERN_LEN_RST;
			pattern_reg = '0;
			ctx_len_reg = CONTEXT_LEN_RST;
			failures = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			foreach (window[k])
				window[k] = 8'h00;
			position = '0;
			next_start = '0;
			capture_left = 0;
		endfunction

		// length clamped into 1..MAX_PAT
		function int unsigned eff_pattern_len();
			if (pat_len_reg == 6'd0)
				return 1;
			if (pat_len_reg > MAX_PAT)
				return MAX_PAT;
			return pat_len_reg;
		endfunction

		function logic [7:0] spaced(input logic [7:0] b);
			return (b == 8'h00) ? SPACE_BYTE : b;
		endfunction

		function void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
			case (idx)
				REG_PATTERN_LEN:   pat_len_reg = value[5:0];
				REG_PATTERN_WORD0: pattern_reg[63:0] = value;
				REG_PATTERN_WORD1: pattern_reg[127:64] = value;
				REG_PATTERN_WORD2: pattern_reg[191:128] = value;
				REG_PATTERN_WORD3: pattern_reg[255:192] = value;
				REG_CONTEXT_LEN:   ctx_len_reg = value[7:0];
				default: ;
			endcase
		endfunction

		// one accepted stream byte: queue the record items it causes
		function void note_byte(input logic [7:0] b, input logic eos);
			int unsigned      plen;
			int unsigned      ctx;
			int unsigned      reps;
			int unsigned      added;
			logic [OFS_W-1:0] start;
			logic             hit;
			record_item_t     item;

			plen = eff_pattern_len();
			ctx = (ctx_len_reg == 8'd0) ? 1 : ctx_len_reg;
			added = 0;
			for (int k = MAX_PAT - 1; k > 0; k--)
				window[k] = window[k-1];
			window[0] = b;

			if (capture_left > 0) begin
				item = '{'0, spaced(b), 1'b0, capture_left == 1};
				pending.push_back(item);
				added = 1;
				capture_left--;
			end else if (position >= OFS_W'(plen - 1)) begin
				start = position - OFS_W'(plen - 1);
				hit = (start >= next_start);
				for (int k = 0; k < plen; k++)
					if (pattern_reg[8*k +: 8] != window[plen-1-k])
						hit = 1'b0;
				if (hit) begin
					reps = (ctx < plen) ? ctx : plen;
					for (int j = 0; j < reps; j++) begin
						item = '{(j == 0) ? start : '0, spaced(window[plen-1-j]),
							j == 0, (j == reps - 1) && (ctx == reps)};
						pending.push_back(item);
					end
					added = reps;
					capture_left = ctx - reps;
					next_start = start + OFS_W'(ctx);
				end
			end

			if (eos) begin
				if (added > 0) begin
					item = pending[pending.size()-1];
					item.last_of_record = 1'b1;
					pending[pending.size()-1] = item;
				end
				clear_stream();
			end else begin
				position = position + 1'b1;
			end
		endfunction

		function void check_record(input record_item_t got);
			record_item_t want;
			if (pending.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("unexpected record item: offset %h byte %h first %b last %b",
						got.match_offset, got.context_byte, got.first_of_record,
						got.last_of_record);
				failures++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				if (failures < MAX_REPORTS)
					$display("record item mismatch: offset %h/%h byte %h/%h first %b/%b last %b/%b (exp/got)",
						want.match_offset, got.match_offset,
						want.context_byte, got.context_byte,
						want.first_of_record, got.first_of_record,
						want.last_of_record, got.last_of_record);
				failures++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block and channels
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	psc_stream_if stream_ch ();
	psc_record_if #(.OFFSET_BITS(OFS_W)) record_ch ();

	pattern_search_context_capture #(
		.MAX_PATTERN(MAX_PAT),
		.OFFSET_BITS(OFS_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_ch),
		.record(record_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	record_scoreboard sb = new();

	// sender burst bookkeeping
	int unsigned burst_left = 0;
	int unsigned items_accepted = 0;

	// receiver state; the main process asks for the long hold-off by a flag
	bit          hold_request = 1'b0;
	int unsigned hold_left = 0;
	int unsigned stall_tick = 0;
	sink_mode_t  stall_mode = SINK_OPEN;

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// overall time limit
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL pattern_search_context_capture");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver: check each accepted record item, then pick next ready
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (record_ch.valid === 1'b1 && record_ch.ready === 1'b1)
			sb.check_record({record_ch.match_offset, record_ch.context_byte,
				record_ch.first_of_record, record_ch.last_of_record});

		stall_tick++;
		// switch stall pattern now and then, open stretches included
		if (stall_tick % 48 == 0)
			stall_mode = sink_mode_t'($urandom_range(0, 3));
		if (hold_request) begin
			hold_left = HOLD_OFF_CYCLES;
			hold_request = 1'b0;
		end

		if (hold_left > 0) begin
			// long hold-off: the block fills up and must stall its input
			hold_left--;
			record_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				SINK_OPEN:     record_ch.ready <= 1'b1;
				SINK_COIN:     record_ch.ready <= 1'($urandom_range(0, 1));
				SINK_SLOW:     record_ch.ready <= ($urandom_range(0, 3) == 0);
				default:       record_ch.ready <= ((stall_tick % 5) < 3);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// sender and configuration tasks
	// ------------------------------------------------------------------------

	// offer one item and hold it until taken; bursts keep valid high
	task automatic send_item(input logic [7:0] b, input logic eos);
		int unsigned gap;
		stream_ch.valid <= 1'b1;
		stream_ch.data_byte <= b;
		stream_ch.end_of_stream <= eos;
		@(posedge clk);
		while (stream_ch.ready !== 1'b1)
			@(posedge clk);
		sb.note_byte(b, eos);
		items_accepted++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// a gap after the burst ends, so valid never drops and rises in one step
			stream_ch.valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// stop offering, let every expected item arrive, then let the block settle
	task automatic wait_idle();
		stream_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.apply_reg(idx, value);
	endtask

	// write all six registers back to back, then release the write enable
	task automatic load_setup(input logic [5:0] plen, input logic [255:0] pattern,
			input logic [7:0] ctx);
		cfg_write(REG_PATTERN_LEN, {58'd0, plen});
		cfg_write(REG_PATTERN_WORD0, pattern[63:0]);
		cfg_write(REG_PATTERN_WORD1, pattern[127:64]);
		cfg_write(REG_PATTERN_WORD2, pattern[191:128]);
		cfg_write(REG_PATTERN_WORD3, pattern[255:192]);
		cfg_write(REG_CONTEXT_LEN, {56'd0, ctx});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly full pattern copies, some broken prefixes, some noise
	task automatic send_stream(input int unsigned target, input bit close);
		logic [7:0]  bytes [$];
		int unsigned plen;
		int unsigned cut;
		int unsigned choice;
		plen = sb.eff_pattern_len();
		while (bytes.size() < target) begin
			choice = $urandom_range(0, 99);
			if (choice < 55) begin
				for (int k = 0; k < plen; k++)
					bytes.push_back(sb.pattern_reg[8*k +: 8]);
			end else if (choice < 70) begin
				cut = $urandom_range(0, plen - 1);
				for (int k = 0; k < cut; k++)
					bytes.push_back(sb.pattern_reg[8*k +: 8]);
				bytes.push_back(8'($urandom));
			end else begin
				// zero bytes often, to see them turned into spaces
				repeat ($urandom_range(1, 4))
					bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			end
		end
		foreach (bytes[i])
			send_item(bytes[i], close && (i == bytes.size() - 1));
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		logic [255:0] pat;
		logic [5:0]   plen;
		logic [7:0]   ctx;
		int unsigned  target;
		int unsigned  phase;
		int unsigned  pick;
		int unsigned  directed_items;
		bit           close;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stream_ch.valid = 1'b0;
		stream_ch.data_byte = 8'h00;
		stream_ch.end_of_stream = 1'b0;
		record_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one zero byte pattern, 200 byte records,
		// the record opened at offset 1 is cut by end of stream
		send_item(8'h5A, 1'b0);
		send_item(8'h00, 1'b1);
		wait_idle();

		// zero pattern length acts as one, zero context length acts as one
		load_setup(6'd0, 256'h0, 8'd0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h00, 1'b1);
		wait_idle();

		// context shorter than pattern; a prefix at stream start, end of
		// stream on a byte that causes nothing
		load_setup(6'd5, 256'h7F_FF_00_01_80, 8'd2);
		send_item(8'h80, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h7F, 1'b1);
		wait_idle();

		// pattern seen again inside a record is only captured; end of
		// stream closes the open record
		load_setup(6'd2, 256'h55_AA, 8'd32);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(8'h22, 1'b1);
		directed_items = items_accepted;

		// random phases: fixed extremes first, then random settings
		phase = 0;
		while (phase < 4 || items_accepted - directed_items < 60) begin
			wait_idle();
			pat = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			close = 1'b1;
			case (phase)
				0: begin
					// longest pattern, record just as long as the pattern
					plen = 6'd32;
					ctx = 8'd32;
					target = 32;
				end
				1: begin
					// single byte pattern, longest record
					plen = 6'd1;
					ctx = 8'd255;
					target = 12;
				end
				2: begin
					// length above the maximum and zero context
					plen = 6'd63;
					ctx = 8'd0;
					target = 32;
				end
				default: begin
					pick = $urandom_range(0, 99);
					if (pick < 70)
						plen = 6'($urandom_range(1, 6));
					else if (pick < 85)
						plen = 6'($urandom_range(7, 32));
					else
						plen = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
					pick = $urandom_range(0, 99);
					if (pick < 60)
						ctx = 8'($urandom_range(32, 64));
					else if (pick < 80)
						ctx = 8'($urandom_range(0, 31));
					else
						ctx = 8'($urandom_range(65, 255));
					target = $urandom_range(8, 16);
					// now and then leave the stream open across a register change
					close = ($urandom_range(0, 6) != 0);
				end
			endcase
			load_setup(plen, pat, ctx);
			if (phase == 1)
				hold_request = 1'b1;
			send_stream(target, close);
			phase++;
		end

		// drain and settle
		stream_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("PASS pattern_search_context_capture");
		else
			$display("FAIL pattern_search_context_capture");
		$finish;
	end

endmodule
